>>> hdl/lapsw_pkg.sv
// shared constants and types for the lap stopwatch
package lapsw_pkg;

    // lap store size and derived widths
    localparam int LAP_SLOTS  = 8;
    localparam int LAP_CNT_W  = $clog2(LAP_SLOTS + 1);
    localparam int LAP_IDX_W  = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;

    // field widths
    localparam int REQ_W      = 3;
    localparam int STATE_W    = 2;
    localparam int HOUR_W     = 7;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int MS_W       = 10;
    localparam int EVENT_W    = 3;
    localparam int LAPTIME_W  = HOUR_W + MIN_W + SEC_W + MS_W;
    localparam int IDLE_W     = 16;

    // counter limits
    localparam logic [MS_W-1:0]   MS_MAX     = 10'd999;
    localparam logic [MS_W-1:0]   MS_HALF    = 10'd500;
    localparam logic [SEC_W-1:0]  SEC_MAX    = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_MAX    = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_MAX   = 7'd99;
    localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd30000;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_EXIT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_START = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LAP   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_VIEW  = 3'd4;

    // lap event codes
    localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SAVED = 3'd1;
    localparam logic [EVENT_W-1:0] EV_FULL  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SHOWN = 3'd3;
    localparam logic [EVENT_W-1:0] EV_NOLAP = 3'd4;

    // one result item
    typedef struct packed {
        logic [STATE_W-1:0]   run_state;
        logic [HOUR_W-1:0]    hours;
        logic [MIN_W-1:0]     minutes;
        logic [SEC_W-1:0]     seconds;
        logic [MS_W-1:0]      millis;
        logic                 dot_on;
        logic [EVENT_W-1:0]   lap_event;
        logic [LAP_CNT_W-1:0] lap_number;
        logic [LAP_CNT_W-1:0] lap_total;
        logic [LAPTIME_W-1:0] lap_stamp;
        logic                 exit_to_clock;
        logic                 view_led;
    } t_result;

endpackage

>>> hdl/lapsw_core.sv
// stopwatch state, lap store and per-item update logic
module lapsw_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [lapsw_pkg::REQ_W-1:0]  i_req,
    input  logic                         i_held,
    input  logic                         i_cfg_we,
    input  logic [lapsw_pkg::IDLE_W-1:0] i_cfg_wdata,
    output lapsw_pkg::t_result           o_res
);
    import lapsw_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        ST_STOPPED = 2'd0,
        ST_RUNNING = 2'd1,
        ST_PAUSED  = 2'd2
    } t_run_state;

    t_run_state           r_state, n_state;
    logic [HOUR_W-1:0]    r_hour, n_hour;
    logic [MIN_W-1:0]     r_min, n_min;
    logic [SEC_W-1:0]     r_sec, n_sec;
    logic [MS_W-1:0]      r_ms, n_ms;
    logic [LAP_CNT_W-1:0] r_laps, n_laps;
    logic [LAP_CNT_W-1:0] r_view, n_view;
    logic                 r_led, n_led;
    logic [IDLE_W-1:0]    r_idle, n_idle;
    logic [IDLE_W-1:0]    r_timeout;
    logic [LAPTIME_W-1:0] r_store [LAP_SLOTS];

    logic                 store_we;
    logic [LAP_CNT_W-1:0] view_sel;
    logic [EVENT_W-1:0]   ev;
    logic [LAP_CNT_W-1:0] num;
    logic [LAPTIME_W-1:0] ltime;
    logic                 exit_f;

    always_comb begin
        n_state  = r_state;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;
        n_ms     = r_ms;
        n_laps   = r_laps;
        n_view   = r_view;
        n_led    = r_led;
        n_idle   = r_idle;
        store_we = 1'b0;
        view_sel = '0;
        ev       = EV_NONE;
        num      = '0;
        ltime    = '0;
        exit_f   = 1'b0;

        case (i_req)
            REQ_TICK: begin
                if (r_state == ST_RUNNING) begin
                    // cascaded carry through ms, s, min, h
                    if (r_ms == MS_MAX) begin
                        n_ms = '0;
                        if (r_sec == SEC_MAX) begin
                            n_sec = '0;
                            if (r_min == MIN_MAX) begin
                                n_min  = '0;
                                n_hour = (r_hour == HOUR_MAX) ? '0 : r_hour + 1'b1;
                            end else begin
                                n_min = r_min + 1'b1;
                            end
                        end else begin
                            n_sec = r_sec + 1'b1;
                        end
                    end else begin
                        n_ms = r_ms + 1'b1;
                    end
                end
            end
            REQ_EXIT: begin
                exit_f = 1'b1;
            end
            REQ_START: begin
                n_state = (r_state == ST_RUNNING) ? ST_PAUSED : ST_RUNNING;
            end
            REQ_LAP: begin
                if (r_state == ST_PAUSED) begin
                    n_state = ST_STOPPED;
                    n_hour  = '0;
                    n_min   = '0;
                    n_sec   = '0;
                    n_ms    = '0;
                    n_laps  = '0;
                    n_view  = '0;
                    n_led   = 1'b0;
                end else if (r_state == ST_RUNNING) begin
                    if (r_laps >= LAP_CNT_W'(LAP_SLOTS)) begin
                        ev = EV_FULL;
                    end else begin
                        ltime    = {r_hour, r_min, r_sec, r_ms};
                        store_we = 1'b1;
                        n_laps   = r_laps + 1'b1;
                        ev       = EV_SAVED;
                        num      = n_laps;
                    end
                end
            end
            REQ_VIEW: begin
                n_led = ~r_led;
                if (r_laps == '0) begin
                    ev = EV_NOLAP;
                end else begin
                    // restart at the first lap once past the last one
                    view_sel = (r_view >= r_laps) ? '0 : r_view;
                    ev       = EV_SHOWN;
                    num      = view_sel + 1'b1;
                    ltime    = r_store[view_sel[LAP_IDX_W-1:0]];
                    n_view   = view_sel + 1'b1;
                end
            end
            default: begin
            end
        endcase

        // idle timeout only counts ticks while stopped with nothing held
        if (n_state != ST_STOPPED || i_held) begin
            n_idle = '0;
        end else if (i_req == REQ_TICK) begin
            if (r_idle >= r_timeout) begin
                exit_f = 1'b1;
                n_idle = '0;
            end else begin
                n_idle = r_idle + 1'b1;
            end
        end
    end

    always_comb begin
        o_res.run_state     = n_state;
        o_res.hours         = n_hour;
        o_res.minutes       = n_min;
        o_res.seconds       = n_sec;
        o_res.millis        = n_ms;
        o_res.dot_on        = (n_ms < MS_HALF);
        o_res.lap_event     = ev;
        o_res.lap_number    = num;
        o_res.lap_total     = n_laps;
        o_res.lap_stamp     = ltime;
        o_res.exit_to_clock = exit_f;
        o_res.view_led      = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_STOPPED;
            r_hour    <= '0;
            r_min     <= '0;
            r_sec     <= '0;
            r_ms      <= '0;
            r_laps    <= '0;
            r_view    <= '0;
            r_led     <= 1'b0;
            r_idle    <= '0;
            r_timeout <= IDLE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_step) begin
                r_state <= n_state;
                r_hour  <= n_hour;
                r_min   <= n_min;
                r_sec   <= n_sec;
                r_ms    <= n_ms;
                r_laps  <= n_laps;
                r_view  <= n_view;
                r_led   <= n_led;
                r_idle  <= n_idle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[r_laps[LAP_IDX_W-1:0]] <= ltime;
        end
    end

endmodule

>>> hdl/lap_stopwatch_top.sv
// top level of the lap stopwatch: input register, update logic, result register
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser req_type, tdata buttons_held
// m_axis    out  m_axis_tvalid/tready      tuser lap_event, tdata status and time
// cfg       in   i_cfg_we                  i_cfg_wdata idle_timeout
//
// one item per cycle while m_axis_tready keeps the output moving; a taken item
// passes the input register, then the update into the result register
// reset is synchronous, active low; it stops the watch and clears time, laps
// and the idle timeout back to 30000 ticks
// a stalled result holds in the output register while one more item waits in
// the input register; s_axis_tready drops only when both are full
module lap_stopwatch_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] buttons_held, [7:1] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] run_state, [8:2] hours, [14:9] minutes, [20:15] seconds,
    // [30:21] millis, [31] dot_on, [35:32] lap_number, [39:36] lap_total,
    // [68:40] lap_stamp, [69] exit_to_clock, [70] view_led, [71] zero
    output logic [71:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] lap_event
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import lapsw_pkg::*;

    logic             r_in_valid;
    logic [REQ_W-1:0] r_in_req;
    logic             r_in_held;
    logic             r_out_valid;
    t_result          r_out;
    t_result          core_res;
    logic             advance;
    logic             s_accept;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    lapsw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_req       (r_in_req),
        .i_held      (r_in_held),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_req  <= s_axis_tuser;
            r_in_held <= s_axis_tdata[0];
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.lap_event;
    assign m_axis_tdata  = {1'b0,
                            r_out.view_led,
                            r_out.exit_to_clock,
                            r_out.lap_stamp,
                            r_out.lap_total,
                            r_out.lap_number,
                            r_out.dot_on,
                            r_out.millis,
                            r_out.seconds,
                            r_out.minutes,
                            r_out.hours,
                            r_out.run_state};

endmodule
